>>> design/clmt_pkg.sv
// clmt_pkg: shared types and codes of the cell list membership table.
// Used by clmt_ctrl, clmt_dpath and cell_list_membership_table.
// No dependencies.
package clmt_pkg;

    // Default sizing of the storage
    localparam int DEF_MAX_PARTICLES = 1024;
    localparam int DEF_GRID_X        = 16;
    localparam int DEF_GRID_Y        = 16;

    // Command codes of an input item
    localparam logic [1:0] CMD_PLACE = 2'd0;
    localparam logic [1:0] CMD_HEAD  = 2'd1;
    localparam logic [1:0] CMD_LINKS = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_LINK  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_BOXES_X        = 2'd0;
    localparam logic [1:0] CFG_BOXES_Y        = 2'd1;
    localparam logic [1:0] CFG_PARTICLE_COUNT = 2'd2;

    // Configuration reset values
    localparam logic [4:0]  RST_BOXES_X        = 5'd16;
    localparam logic [4:0]  RST_BOXES_Y        = 5'd16;
    localparam logic [10:0] RST_PARTICLE_COUNT = 11'd1024;

    typedef struct packed {
        logic [4:0]  boxes_x;
        logic [4:0]  boxes_y;
        logic [10:0] particle_count;
    } cfg_t;

    // Per-particle box entry: placed bit and box coordinates
    typedef struct packed {
        logic       placed;
        logic [3:0] x;
        logic [3:0] y;
    } pbox_t;

    // Controller to datapath
    typedef struct packed {
        logic clear;        // clearing sweep step
        logic load_item;    // capture accepted item
        logic look;         // read head[new box] and particle entries
        logic eval;         // capture head of new box
        logic rd_ob;        // read head[old box]
        logic check;        // link check and unlink writes
        logic push;         // push at new box head
        logic fixup;        // back link of the old head
        logic load_result;  // load the output register
    } clmt_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;
        logic range_bad;
        logic is_place;
        logic placed;
        logic same_box;
        logic link_bad;
    } clmt_stat_t;

endpackage

>>> design/clmt_ctrl.sv
// clmt_ctrl: sequencing state machine of the cell list membership table.
// Depends on clmt_pkg; drives clmt_dpath through clmt_cmd_t.
module clmt_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output clmt_pkg::clmt_cmd_t cmd,
    input  clmt_pkg::clmt_stat_t st
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_EVAL,
        S_CHECK,
        S_PUSH,
        S_FIXUP,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clear = 1'b1;
                if (st.clear_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = S_LOOK;
                end
            end
            S_LOOK: begin
                cmd.look   = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL: begin
                cmd.eval = 1'b1;
                if (st.range_bad || !st.is_place || (st.placed && st.same_box)) begin
                    state_next = S_DONE;
                end else if (!st.placed) begin
                    state_next = S_PUSH;
                end else begin
                    cmd.rd_ob  = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                cmd.check  = 1'b1;
                state_next = st.link_bad ? S_DONE : S_PUSH;
            end
            S_PUSH: begin
                cmd.push   = 1'b1;
                state_next = S_FIXUP;
            end
            S_FIXUP: begin
                cmd.fixup  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.load_result = 1'b1;
                    m_valid_next    = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

>>> design/clmt_dpath.sv
// clmt_dpath: memories, item and result registers of the cell list table.
// Depends on clmt_pkg; commanded by clmt_ctrl.
module clmt_dpath #(
    parameter int MAX_PARTICLES = clmt_pkg::DEF_MAX_PARTICLES,
    parameter int GRID_X        = clmt_pkg::DEF_GRID_X,
    parameter int GRID_Y        = clmt_pkg::DEF_GRID_Y
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  clmt_pkg::cfg_t       cfg,
    input  clmt_pkg::clmt_cmd_t  cmd,
    output clmt_pkg::clmt_stat_t st,
    input  logic [1:0]           s_cmd,
    input  logic [9:0]           s_particle,
    input  logic [3:0]           s_box_x,
    input  logic [3:0]           s_box_y,
    output logic [1:0]           m_status,
    output logic                 m_changed,
    output logic                 m_was_placed,
    output logic [3:0]           m_cur_box_x,
    output logic [3:0]           m_cur_box_y,
    output logic                 m_head_valid,
    output logic [9:0]           m_head_index,
    output logic                 m_next_valid,
    output logic [9:0]           m_next_index,
    output logic                 m_prev_valid,
    output logic [9:0]           m_prev_index
);

    localparam int NBOX  = GRID_X * GRID_Y;
    localparam int PW    = $clog2(MAX_PARTICLES);
    localparam int LW    = PW + 1;                 // link: valid + index
    localparam int BW    = (NBOX > 1) ? $clog2(NBOX) : 1;
    localparam int CLR_N = (NBOX > MAX_PARTICLES) ? NBOX : MAX_PARTICLES;
    localparam int CW    = $clog2(CLR_N);

    // storage
    logic [LW-1:0]   head_mem [NBOX];
    logic [LW-1:0]   next_mem [MAX_PARTICLES];
    logic [LW-1:0]   prev_mem [MAX_PARTICLES];
    clmt_pkg::pbox_t pbox_mem [MAX_PARTICLES];

    // registered read data
    logic [LW-1:0]   head_q, next_q, prev_q;
    clmt_pkg::pbox_t pbox_q;

    // item, captured head and check flag
    logic [1:0]    cmd_reg;
    logic [9:0]    part_reg;
    logic [3:0]    bx_reg, by_reg;
    logic [LW-1:0] k_reg;
    logic          link_bad_reg;
    logic [CW-1:0] clr_cnt_reg;

    // output registers
    logic [1:0] status_reg;
    logic       changed_reg, was_placed_reg, head_valid_reg, next_valid_reg, prev_valid_reg;
    logic [3:0] cur_x_reg, cur_y_reg;
    logic [9:0] head_index_reg, next_index_reg, prev_index_reg;

    logic          part_ok, box_ok, range_bad, same_box, is_head, link_bad;
    logic [PW-1:0] p_idx;
    logic [BW-1:0] nb, ob;
    logic [LW-1:0] nx_eff;
    logic          nx_v, k_ok, clr_box, clr_part;

    // write and read ports
    logic          head_we, head_re, next_we, prev_we, pbox_we;
    logic [BW-1:0] head_wa, head_ra;
    logic [LW-1:0] head_wd, next_wd, prev_wd;
    logic [PW-1:0] next_wa, prev_wa, pbox_wa;
    clmt_pkg::pbox_t pbox_wd;

    // ---------------- checks and addresses ----------------
    assign part_ok = ({1'b0, part_reg} < cfg.particle_count) && (32'(part_reg) < MAX_PARTICLES);
    assign box_ok  = ({1'b0, bx_reg} < cfg.boxes_x) && (32'(bx_reg) < GRID_X)
                  && ({1'b0, by_reg} < cfg.boxes_y) && (32'(by_reg) < GRID_Y);

    always_comb begin
        case (cmd_reg)
            clmt_pkg::CMD_PLACE: range_bad = !part_ok || !box_ok;
            clmt_pkg::CMD_HEAD:  range_bad = !box_ok;
            clmt_pkg::CMD_LINKS: range_bad = !part_ok;
            default:             range_bad = 1'b1;
        endcase
    end

    assign p_idx    = PW'(part_reg);
    assign nb       = BW'(32'(bx_reg) * GRID_Y + 32'(by_reg));
    assign ob       = BW'(32'(pbox_q.x) * GRID_Y + 32'(pbox_q.y));
    assign same_box = (pbox_q.x == bx_reg) && (pbox_q.y == by_reg);

    // head_q holds head[old box] during the check
    assign is_head  = head_q[LW-1] && (head_q[PW-1:0] == p_idx);
    assign link_bad = !is_head && !(prev_q[LW-1] && (32'(prev_q[PW-1:0]) < MAX_PARTICLES));
    assign nx_eff   = (32'(next_q[PW-1:0]) < MAX_PARTICLES) ? next_q : '0;
    assign nx_v     = nx_eff[LW-1];
    assign k_ok     = k_reg[LW-1] && (32'(k_reg[PW-1:0]) < MAX_PARTICLES);

    assign clr_box  = 32'(clr_cnt_reg) < NBOX;
    assign clr_part = 32'(clr_cnt_reg) < MAX_PARTICLES;

    assign st.clear_last = (clr_cnt_reg == CW'(CLR_N - 1));
    assign st.range_bad  = range_bad;
    assign st.is_place   = (cmd_reg == clmt_pkg::CMD_PLACE);
    assign st.placed     = pbox_q.placed;
    assign st.same_box   = same_box;
    assign st.link_bad   = link_bad;

    // ---------------- port steering ----------------
    always_comb begin
        head_we = 1'b0; head_wa = '0; head_wd = '0;
        next_we = 1'b0; next_wa = '0; next_wd = '0;
        prev_we = 1'b0; prev_wa = '0; prev_wd = '0;
        pbox_we = 1'b0; pbox_wa = '0; pbox_wd = '0;
        if (cmd.clear) begin
            head_we = clr_box;
            head_wa = BW'(clr_cnt_reg);
            pbox_we = clr_part;
            pbox_wa = PW'(clr_cnt_reg);
        end else if (cmd.check && !link_bad) begin
            // unlink from the old box
            prev_we = nx_v;
            prev_wa = nx_eff[PW-1:0];
            if (is_head) begin
                head_we = 1'b1;
                head_wa = ob;
                head_wd = nx_eff;
            end else begin
                next_we = 1'b1;
                next_wa = prev_q[PW-1:0];
                next_wd = nx_eff;
                prev_wd = prev_q;
            end
        end else if (cmd.push) begin
            head_we = 1'b1;
            head_wa = nb;
            head_wd = {1'b1, p_idx};
            prev_we = 1'b1;
            prev_wa = p_idx;
            next_we = 1'b1;
            next_wa = p_idx;
            next_wd = k_reg;
            pbox_we = 1'b1;
            pbox_wa = p_idx;
            pbox_wd = '{placed: 1'b1, x: bx_reg, y: by_reg};
        end else if (cmd.fixup) begin
            prev_we = k_ok;
            prev_wa = k_reg[PW-1:0];
            prev_wd = {1'b1, p_idx};
        end
    end

    assign head_re = cmd.look || cmd.rd_ob;
    assign head_ra = cmd.look ? nb : ob;

    // ---------------- memories ----------------
    always_ff @(posedge aclk) begin
        if (head_we) head_mem[head_wa] <= head_wd;
        if (head_re) head_q <= head_mem[head_ra];
    end

    always_ff @(posedge aclk) begin
        if (next_we) next_mem[next_wa] <= next_wd;
        if (cmd.look) next_q <= next_mem[p_idx];
    end

    always_ff @(posedge aclk) begin
        if (prev_we) prev_mem[prev_wa] <= prev_wd;
        if (cmd.look) prev_q <= prev_mem[p_idx];
    end

    always_ff @(posedge aclk) begin
        if (pbox_we) pbox_mem[pbox_wa] <= pbox_wd;
        if (cmd.look) pbox_q <= pbox_mem[p_idx];
    end

    // ---------------- control registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clear && !st.clear_last) begin
            clr_cnt_reg <= clr_cnt_reg + CW'(1);
        end
    end

    // ---------------- item and working registers ----------------
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            cmd_reg  <= s_cmd;
            part_reg <= s_particle;
            bx_reg   <= s_box_x;
            by_reg   <= s_box_y;
        end
        if (cmd.eval)  k_reg <= head_q;
        if (cmd.check) link_bad_reg <= link_bad;
    end

    // ---------------- result ----------------
    always_ff @(posedge aclk) begin
        if (cmd.load_result) begin
            status_reg     <= clmt_pkg::STAT_OK;
            changed_reg    <= 1'b0;
            was_placed_reg <= 1'b0;
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            head_valid_reg <= 1'b0;
            head_index_reg <= '0;
            next_valid_reg <= 1'b0;
            next_index_reg <= '0;
            prev_valid_reg <= 1'b0;
            prev_index_reg <= '0;
            if (range_bad) begin
                status_reg <= clmt_pkg::STAT_RANGE;
            end else if (cmd_reg == clmt_pkg::CMD_HEAD) begin
                head_valid_reg <= k_reg[LW-1];
                head_index_reg <= k_reg[LW-1] ? 10'(k_reg[PW-1:0]) : '0;
            end else if (pbox_q.placed) begin
                was_placed_reg <= 1'b1;
                cur_x_reg      <= pbox_q.x;
                cur_y_reg      <= pbox_q.y;
                if (cmd_reg == clmt_pkg::CMD_LINKS) begin
                    next_valid_reg <= next_q[LW-1];
                    next_index_reg <= next_q[LW-1] ? 10'(next_q[PW-1:0]) : '0;
                    prev_valid_reg <= prev_q[LW-1];
                    prev_index_reg <= prev_q[LW-1] ? 10'(prev_q[PW-1:0]) : '0;
                end else if (!same_box) begin
                    if (link_bad_reg) status_reg <= clmt_pkg::STAT_LINK;
                    else changed_reg <= 1'b1;
                end
            end else if (cmd_reg == clmt_pkg::CMD_PLACE) begin
                changed_reg <= 1'b1;
            end
        end
    end

    assign m_status     = status_reg;
    assign m_changed    = changed_reg;
    assign m_was_placed = was_placed_reg;
    assign m_cur_box_x  = cur_x_reg;
    assign m_cur_box_y  = cur_y_reg;
    assign m_head_valid = head_valid_reg;
    assign m_head_index = head_index_reg;
    assign m_next_valid = next_valid_reg;
    assign m_next_index = next_index_reg;
    assign m_prev_valid = prev_valid_reg;
    assign m_prev_index = prev_index_reg;

endmodule

>>> design/cell_list_membership_table.sv
// cell_list_membership_table: top level, configuration registers and checks.
// Depends on clmt_pkg, clmt_ctrl and clmt_dpath.
//
// Keeps doubly linked cell lists: a head entry per grid box (box index is
// box_x * GRID_Y + box_y) and per particle a next link, a prev link, its box
// and a placed bit. Command 0 places a particle (pushed at the head of the
// target box; a move first unlinks it from its old box; the same box is a
// no-op), command 1 reads a box head, command 2 reads a particle's box and
// links. Out-of-range particles or boxes and unknown commands give status 1;
// a move whose old links do not check out gives status 2 and changes nothing.
// One item is processed at a time, and each memory has one read and one
// write port, so the cost per item follows the memory accesses it needs:
// after the accept come S_LOOK and S_EVAL; a move adds S_CHECK, a place
// that changes a box adds S_PUSH and S_FIXUP (a move refused for bad links
// skips them), and S_DONE loads the result once the output is free. The
// result sits in an output register, so the next item is accepted while
// the previous result waits for m_ready.
// After reset a clearing sweep empties the head table and placed bits, one
// entry per cycle over max(GRID_X*GRID_Y, MAX_PARTICLES) entries (1024 at the
// defaults); s_ready stays low meanwhile, configuration writes are taken at
// any time (cfg_ready is always high). Write configuration only while idle.
module cell_list_membership_table #(
    parameter int MAX_PARTICLES = clmt_pkg::DEF_MAX_PARTICLES,
    parameter int GRID_X        = clmt_pkg::DEF_GRID_X,
    parameter int GRID_Y        = clmt_pkg::DEF_GRID_Y
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data,
    // input items
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [9:0]  s_particle,
    input  logic [3:0]  s_box_x,
    input  logic [3:0]  s_box_y,
    // results
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic        m_changed,
    output logic        m_was_placed,
    output logic [3:0]  m_cur_box_x,
    output logic [3:0]  m_cur_box_y,
    output logic        m_head_valid,
    output logic [9:0]  m_head_index,
    output logic        m_next_valid,
    output logic [9:0]  m_next_index,
    output logic        m_prev_valid,
    output logic [9:0]  m_prev_index
);

    clmt_pkg::cfg_t       cfg_reg;
    clmt_pkg::clmt_cmd_t  cmd;
    clmt_pkg::clmt_stat_t st;

    // Config transfers are never stalled
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.boxes_x        <= clmt_pkg::RST_BOXES_X;
            cfg_reg.boxes_y        <= clmt_pkg::RST_BOXES_Y;
            cfg_reg.particle_count <= clmt_pkg::RST_PARTICLE_COUNT;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                clmt_pkg::CFG_BOXES_X:        cfg_reg.boxes_x        <= cfg_data[4:0];
                clmt_pkg::CFG_BOXES_Y:        cfg_reg.boxes_y        <= cfg_data[4:0];
                clmt_pkg::CFG_PARTICLE_COUNT: cfg_reg.particle_count <= cfg_data;
                default: ;  // unused index: write ignored
            endcase
        end
    end

    // Sequencer: one item in flight, walks the memory accesses
    clmt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .st      (st)
    );

    // Memories, link update logic and result register
    clmt_dpath #(
        .MAX_PARTICLES (MAX_PARTICLES),
        .GRID_X        (GRID_X),
        .GRID_Y        (GRID_Y)
    ) u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .cmd          (cmd),
        .st           (st),
        .s_cmd        (s_cmd),
        .s_particle   (s_particle),
        .s_box_x      (s_box_x),
        .s_box_y      (s_box_y),
        .m_status     (m_status),
        .m_changed    (m_changed),
        .m_was_placed (m_was_placed),
        .m_cur_box_x  (m_cur_box_x),
        .m_cur_box_y  (m_cur_box_y),
        .m_head_valid (m_head_valid),
        .m_head_index (m_head_index),
        .m_next_valid (m_next_valid),
        .m_next_index (m_next_index),
        .m_prev_valid (m_prev_valid),
        .m_prev_index (m_prev_index)
    );

    // ---------------- assertions ----------------

    // reset starts the clearing sweep, no item taken during it
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("item accepted right after reset");

    // one item at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item accepted while one is in flight");

    // a change is only reported with ok status
    a_changed_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_changed |-> m_status == clmt_pkg::STAT_OK)
        else $error("change reported with error status");

    // range errors report nothing else
    a_range_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == clmt_pkg::STAT_RANGE |->
            !m_changed && !m_was_placed && !m_head_valid && !m_next_valid && !m_prev_valid)
        else $error("range error result carries data");

endmodule
